### src/wsd_pkg.sv
// Package for the waypoint steering decision block: widths, codes, reset values,
// the CORDIC arctangent table and the tag that rides along the CORDIC pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CORDIC_W         = 35;
  localparam int ANG_W            = 32;
  localparam int PADDR_W          = 5;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [2:0] {
    CMD_STOP,
    CMD_FORWARD,
    CMD_TURN_POS,
    CMD_TURN_NEG,
    CMD_ARRIVED
  } cmd_t;

  typedef enum logic [2:0] {
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_ARRIVE,
    REG_TOL,
    REG_FWD,
    REG_TURN
  } reg_idx_t;

  localparam logic [31:0] GOAL_X_RST  = 32'd65536;
  localparam logic [31:0] GOAL_Y_RST  = 32'd0;
  localparam logic [15:0] ARRIVE_RST  = 16'd6554;
  localparam logic [13:0] TOL_RST     = 14'd546;
  localparam logic [9:0]  FWD_RST     = 10'd200;
  localparam logic [11:0] TURN_RST    = 12'd330;

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  localparam logic [ANG_W-1:0] ATAN_TURN [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic               op;
    logic [15:0]        heading;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               zero;
  } cord_tag_t;

  // goal minus pose, saturated to 32 bits
  function automatic logic signed [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_diff = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_diff = $signed(d[31:0]);
    end
  endfunction

endpackage

`default_nettype wire

### src/wsd_ifs.sv
// Valid/ready channel interfaces for the pose input and the command output.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wsd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  logic [15:0] heading;

  modport source (output valid, op, pose_x, pose_y, heading, input ready);
  modport sink (input valid, op, pose_x, pose_y, heading, output ready);
endinterface

interface wsd_out_if;
  logic               valid;
  logic               ready;
  wsd_pkg::cmd_t      command;
  logic [9:0]         linear_velocity;
  logic signed [12:0] angular_velocity;
  logic signed [15:0] heading_error;
  logic               still_active;

  modport source (output valid, command, linear_velocity, angular_velocity, heading_error,
                  still_active, input ready);
  modport sink (input valid, command, linear_velocity, angular_velocity, heading_error,
                still_active, output ready);
endinterface

`default_nettype wire

### src/wsd_cordic.sv
// Pipelined vectoring CORDIC: one micro-rotation per stage, bearing as a 32-bit turn angle.
// Depends on wsd_pkg; stage loads come from the pipeline control in the top level.
`timescale 1ns / 1ps
`default_nettype none

module wsd_cordic #(
  parameter int STEPS = wsd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic [STEPS-1:0]             load,
  input  wire logic signed [31:0]           x_in,
  input  wire logic signed [31:0]           y_in,
  input  wire wsd_pkg::cord_tag_t           tag_in,
  output logic [wsd_pkg::ANG_W-1:0]         ang_out,
  output wsd_pkg::cord_tag_t                tag_out
);

  localparam int CW = wsd_pkg::CORDIC_W;

  logic signed [CW-1:0]        xr [STEPS];
  logic signed [CW-1:0]        yr [STEPS];
  logic [wsd_pkg::ANG_W-1:0]   ar [STEPS];
  wsd_pkg::cord_tag_t          tr [STEPS];

  genvar i;
  for (i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0]      xp, yp, xn, yn;
    logic [wsd_pkg::ANG_W-1:0] ap, an;
    wsd_pkg::cord_tag_t        tp;

    if (i == 0) begin : g_first
      logic signed [CW-1:0] xe, ye;
      assign xe = $signed({{(CW-32){x_in[31]}}, x_in});
      assign ye = $signed({{(CW-32){y_in[31]}}, y_in});
      // fold the left half-plane onto the right
      always_comb begin
        if (x_in[31]) begin
          xp = -xe;
          yp = -ye;
          ap = 32'h8000_0000;
        end else begin
          xp = xe;
          yp = ye;
          ap = '0;
        end
      end
      assign tp = tag_in;
    end else begin : g_next
      assign xp = xr[i-1];
      assign yp = yr[i-1];
      assign ap = ar[i-1];
      assign tp = tr[i-1];
    end

    always_comb begin
      if (!yp[CW-1]) begin
        xn = xp + (yp >>> i);
        yn = yp - (xp >>> i);
        an = ap + wsd_pkg::ATAN_TURN[i];
      end else begin
        xn = xp - (yp >>> i);
        yn = yp + (xp >>> i);
        an = ap - wsd_pkg::ATAN_TURN[i];
      end
    end

    always_ff @(posedge clk) begin
      if (load[i]) begin
        xr[i] <= xn;
        yr[i] <= yn;
        ar[i] <= an;
        tr[i] <= tp;
      end
    end
  end

  assign ang_out = ar[STEPS-1];
  assign tag_out = tr[STEPS-1];

endmodule

`default_nettype wire

### src/waypoint_steering_decision.sv
// Top level of the waypoint steering decision block: APB register file, pipeline control,
// offset and square stages, decision and result register. Depends on wsd_pkg, wsd_ifs, wsd_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock on pose_in and keeps taking items while a result waits on
// cmd_out, as long as any pipeline stage is free. An item passes the input register, the
// offset stage, the CORDIC stages and the last stage to the decision, and its result is
// registered into cmd_out; the depth is set by the CORDIC, one micro-rotation per stage.
// Start items and ticks while not driving flow through the pipeline but yield no result.
// The user writes registers over APB only while the block is idle; the block does not
// enforce it. Goal distance is compared squared, so any fixed-point position scale works.
module waypoint_steering_decision #(
  parameter int CORDIC_STEPS = wsd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wsd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  wsd_in_if.sink                           pose_in,
  wsd_out_if.source                        cmd_out
);

  localparam int N = CORDIC_STEPS + 3;

  // registers
  logic [31:0] goal_x, goal_y;
  logic [15:0] arrive_distance;
  logic [13:0] angle_tolerance;
  logic [9:0]  forward_speed;
  logic [11:0] turn_rate;
  logic [31:0] t2;
  logic        active;

  logic        wr;
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x          <= wsd_pkg::GOAL_X_RST;
      goal_y          <= wsd_pkg::GOAL_Y_RST;
      arrive_distance <= wsd_pkg::ARRIVE_RST;
      angle_tolerance <= wsd_pkg::TOL_RST;
      forward_speed   <= wsd_pkg::FWD_RST;
      turn_rate       <= wsd_pkg::TURN_RST;
    end else if (wr) begin
      unique case (wsd_pkg::reg_idx_t'(paddr[4:2]))
        wsd_pkg::REG_GOAL_X: goal_x          <= pwdata;
        wsd_pkg::REG_GOAL_Y: goal_y          <= pwdata;
        wsd_pkg::REG_ARRIVE: arrive_distance <= pwdata[15:0];
        wsd_pkg::REG_TOL:    angle_tolerance <= pwdata[13:0];
        wsd_pkg::REG_FWD:    forward_speed   <= pwdata[9:0];
        wsd_pkg::REG_TURN:   turn_rate       <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wsd_pkg::reg_idx_t'(paddr[4:2]))
      wsd_pkg::REG_GOAL_X: prdata = goal_x;
      wsd_pkg::REG_GOAL_Y: prdata = goal_y;
      wsd_pkg::REG_ARRIVE: prdata = {16'd0, arrive_distance};
      wsd_pkg::REG_TOL:    prdata = {18'd0, angle_tolerance};
      wsd_pkg::REG_FWD:    prdata = {22'd0, forward_speed};
      wsd_pkg::REG_TURN:   prdata = {20'd0, turn_rate};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    t2 <= {16'd0, arrive_distance} * {16'd0, arrive_distance};
  end

  // pipeline control: a stage loads when it or any stage after it is free, or when the last stage is consumed
  logic [N-1:0] v, load, v_shift;
  logic         consume, produce;

  genvar k;
  for (k = 0; k < N; k++) begin : g_load
    assign load[k] = consume || !(&v[N-1:k]);
  end

  assign v_shift       = {v[N-2:0], pose_in.valid};
  assign pose_in.ready = load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (load & v_shift) | (~load & v);
    end
  end

  // stage 0: input register
  logic        op0;
  logic [31:0] px0, py0;
  logic [15:0] hd0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      op0 <= pose_in.op;
      px0 <= pose_in.pose_x;
      py0 <= pose_in.pose_y;
      hd0 <= pose_in.heading;
    end
  end

  // stage 1: saturated offset to the goal
  logic               op1;
  logic [15:0]        hd1;
  logic signed [31:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      op1 <= op0;
      hd1 <= hd0;
      dx1 <= wsd_pkg::sat_diff(goal_x, px0);
      dy1 <= wsd_pkg::sat_diff(goal_y, py0);
    end
  end

  wsd_pkg::cord_tag_t        tag1, tag_c;
  logic [wsd_pkg::ANG_W-1:0] ang_c;

  assign tag1 = '{op: op1, heading: hd1, dx: dx1, dy: dy1, zero: (dx1 == '0) && (dy1 == '0)};

  wsd_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .load    (load[CORDIC_STEPS+1:2]),
    .x_in    (dx1),
    .y_in    (dy1),
    .tag_in  (tag1),
    .ang_out (ang_c),
    .tag_out (tag_c)
  );

  // last pipeline stage: rounded bearing, heading error, squares
  logic [wsd_pkg::ANG_W-1:0] ang_rnd;
  logic [15:0]               bearing;
  logic signed [63:0]        prod_x, prod_y;
  logic                      op_p;
  logic [15:0]               err_p;
  logic [63:0]               sqx_p, sqy_p;

  assign ang_rnd = ang_c + 32'h0000_8000;
  assign bearing = tag_c.zero ? 16'd0 : ang_rnd[31:16];
  assign prod_x  = 64'(tag_c.dx) * 64'(tag_c.dx);
  assign prod_y  = 64'(tag_c.dy) * 64'(tag_c.dy);

  always_ff @(posedge clk) begin
    if (load[N-1]) begin
      op_p  <= tag_c.op;
      err_p <= bearing - tag_c.heading;
      sqx_p <= $unsigned(prod_x);
      sqy_p <= $unsigned(prod_y);
    end
  end

  // decision
  logic [63:0]        d2;
  logic signed [16:0] err_x, tol_x;
  logic               arrived;
  wsd_pkg::cmd_t      cmd_next;
  logic [9:0]         lin_next;
  logic signed [12:0] ang_next;

  assign d2      = sqx_p + sqy_p;
  assign err_x   = $signed({err_p[15], err_p});
  assign tol_x   = $signed({3'b000, angle_tolerance});
  assign arrived = d2 < {32'd0, t2};
  assign produce = v[N-1] && (op_p == wsd_pkg::OP_TICK) && active;
  assign consume = v[N-1] && (!produce || !cmd_out.valid || cmd_out.ready);

  always_comb begin
    cmd_next = wsd_pkg::CMD_STOP;
    lin_next = '0;
    ang_next = '0;
    priority if (arrived) begin
      cmd_next = wsd_pkg::CMD_ARRIVED;
    end else if (err_x > tol_x) begin
      cmd_next = wsd_pkg::CMD_TURN_POS;
      ang_next = $signed({1'b0, turn_rate});
    end else if (err_x < -tol_x) begin
      cmd_next = wsd_pkg::CMD_TURN_NEG;
      ang_next = -$signed({1'b0, turn_rate});
    end else if (d2 > {32'd0, t2}) begin
      cmd_next = wsd_pkg::CMD_FORWARD;
      lin_next = forward_speed;
    end else begin
      cmd_next = wsd_pkg::CMD_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (consume) begin
      if (op_p == wsd_pkg::OP_START) begin
        active <= 1'b1;
      end else if (produce && arrived) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_out.valid <= 1'b0;
    end else if (consume && produce) begin
      cmd_out.valid <= 1'b1;
    end else if (cmd_out.ready) begin
      cmd_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && produce) begin
      cmd_out.command          <= cmd_next;
      cmd_out.linear_velocity  <= lin_next;
      cmd_out.angular_velocity <= ang_next;
      cmd_out.heading_error    <= $signed(err_p);
      cmd_out.still_active     <= !arrived;
    end
  end

  a_ready_on_bubble: assert property (@(posedge clk) disable iff (rst)
    !(&v) |-> pose_in.ready)
    else $error("input stalled with a free pipeline stage");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_out.valid) |-> $past(consume && produce))
    else $error("result appeared without a decided item");

  a_arrive_disarms: assert property (@(posedge clk) disable iff (rst)
    (consume && produce && arrived) |=> !active)
    else $error("block still driving after arrival");

  a_lin_only_fwd: assert property (@(posedge clk) disable iff (rst)
    (cmd_out.valid && (cmd_out.command != wsd_pkg::CMD_FORWARD))
      |-> (cmd_out.linear_velocity == '0))
    else $error("linear velocity on a command other than forward");

endmodule

`default_nettype wire
